// File: sv/capability_table_macros.svh
// Assertion macros for the capability table checker.
`ifndef CAPABILITY_TABLE_MACROS_SVH
`define CAPABILITY_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define CT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/captbl_pkg.sv
// Shared types and constants of the capability table.
`default_nettype none

package captbl_pkg;

   localparam int BADGE_W = 32;
   localparam int KCAP_W  = 32;
   localparam int STAGE_W = 16;
   localparam int LIVE_W  = 7;
   localparam int OP_W    = 2;

   localparam logic [OP_W-1:0] OP_ADD        = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE     = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND_BADGE = 2'd2;
   localparam logic [OP_W-1:0] OP_FIND_KCAP  = 2'd3;

   localparam logic [LIVE_W-1:0] LIVE_MAX = 7'd127;

   typedef struct packed {
      logic [BADGE_W-1:0] badge;
      logic [KCAP_W-1:0]  kcap;
      logic [STAGE_W-1:0] stage;
   } entry_type;

   typedef struct packed {
      logic start;
      logic step;
      logic add;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic scan_end;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// File: sv/capability_table.sv
// Top level of the capability table: append-only entry store with ordered first-match scan.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | operation, badge, kcap, stage_tag
//   rsp_    | out       | rsp_valid/rsp_stall  | found, badge_out, kcap_out, stage_out,
//           |           |                      | table_full, live_count
//
// Add: the ADD state writes the entry, or sets table_full if full; RESULT then loads it out.
// Remove and finds: the scan over the entry memory, one read port, one entry per cycle,
// runs up to the first hit or past the last filled entry; RESULT then loads the result.
// One item is in work at a time; the next is taken while a result waits in rsp_ registers.
// Reset (synchronous) empties the table; entry memories are not cleared.
// A stalled result holds its fields; the scan finishes and waits for the register to free.
`default_nettype none

module capability_table #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic        [captbl_pkg::OP_W-1:0]    req_operation,
   input  wire logic signed [captbl_pkg::BADGE_W-1:0] req_badge,
   input  wire logic        [captbl_pkg::KCAP_W-1:0]  req_kcap,
   input  wire logic        [captbl_pkg::STAGE_W-1:0] req_stage_tag,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_found,
   output logic signed      [captbl_pkg::BADGE_W-1:0] rsp_badge_out,
   output logic             [captbl_pkg::KCAP_W-1:0]  rsp_kcap_out,
   output logic             [captbl_pkg::STAGE_W-1:0] rsp_stage_out,
   output logic                                       rsp_table_full,
   output logic             [captbl_pkg::LIVE_W-1:0]  rsp_live_count
);

   captbl_pkg::cmd_type cmd;
   captbl_pkg::sts_type sts;

   captbl_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .sts           (sts),
      .cmd           (cmd)
   );

   captbl_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_operation  (req_operation),
      .req_badge      (req_badge),
      .req_kcap       (req_kcap),
      .req_stage_tag  (req_stage_tag),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_badge_out  (rsp_badge_out),
      .rsp_kcap_out   (rsp_kcap_out),
      .rsp_stage_out  (rsp_stage_out),
      .rsp_table_full (rsp_table_full),
      .rsp_live_count (rsp_live_count)
   );

endmodule

`default_nettype wire

// File: sv/captbl_ctrl.sv
// Controller state machine of the capability table.
`default_nettype none

module captbl_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [captbl_pkg::OP_W-1:0] req_operation,
   output logic                             req_stall,
   input  captbl_pkg::sts_type              sts,
   output captbl_pkg::cmd_type              cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ADD    = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_RESULT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.start    = accept;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_operation == captbl_pkg::OP_ADD) ? ST_ADD : ST_SCAN;
            end
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_RESULT;
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (sts.hit || sts.scan_end) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/captbl_datapath.sv
// Datapath of the capability table: entry memories, counters, scan and result registers.
`default_nettype none

module captbl_datapath #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic        [captbl_pkg::OP_W-1:0]    req_operation,
   input  wire logic signed [captbl_pkg::BADGE_W-1:0] req_badge,
   input  wire logic        [captbl_pkg::KCAP_W-1:0]  req_kcap,
   input  wire logic        [captbl_pkg::STAGE_W-1:0] req_stage_tag,
   input  captbl_pkg::cmd_type                        cmd,
   output captbl_pkg::sts_type                        sts,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_found,
   output logic signed      [captbl_pkg::BADGE_W-1:0] rsp_badge_out,
   output logic             [captbl_pkg::KCAP_W-1:0]  rsp_kcap_out,
   output logic             [captbl_pkg::STAGE_W-1:0] rsp_stage_out,
   output logic                                       rsp_table_full,
   output logic             [captbl_pkg::LIVE_W-1:0]  rsp_live_count
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   captbl_pkg::entry_type entry_mem [TABLE_DEPTH];
   logic                  removed_mem [TABLE_DEPTH];

   logic [captbl_pkg::OP_W-1:0] op_ff;
   captbl_pkg::entry_type       key_ff;
   logic [CNT_W-1:0]            fill_ff, fill_in;
   logic [CNT_W-1:0]            live_ff, live_in;
   logic [CNT_W-1:0]            rd_idx_ff, rd_idx_in;
   logic                        pend_ff, pend_in;
   logic [IDX_W-1:0]            pend_idx_ff;
   captbl_pkg::entry_type       rd_entry_ff;
   logic                        rd_removed_ff;
   logic                        res_found_ff, res_found_in;
   captbl_pkg::entry_type       res_entry_ff, res_entry_in;
   logic                        res_full_ff, res_full_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        match;
   logic                        hit;
   logic                        rd_en;
   logic                        has_room;
   logic                        add_wr;
   logic                        rem_wr;
   logic [captbl_pkg::LIVE_W-1:0] live_sat;

   always_comb begin
      unique case (op_ff)
         captbl_pkg::OP_ADD:        match = 1'b0;
         captbl_pkg::OP_REMOVE:     match = (rd_entry_ff.badge == key_ff.badge) &&
                                            (rd_entry_ff.kcap == key_ff.kcap);
         captbl_pkg::OP_FIND_BADGE: match = (rd_entry_ff.badge == key_ff.badge);
         captbl_pkg::OP_FIND_KCAP:  match = (rd_entry_ff.kcap == key_ff.kcap);
         default:                   match = 1'b0;
      endcase
   end

   assign hit      = pend_ff && !rd_removed_ff && match;
   assign has_room = (fill_ff < DEPTH_CNT);
   assign rd_en    = cmd.step && !hit && (rd_idx_ff < fill_ff);
   assign add_wr   = cmd.add && has_room;
   assign rem_wr   = cmd.step && hit && (op_ff == captbl_pkg::OP_REMOVE);

   assign sts.hit      = hit;
   assign sts.scan_end = !hit && (rd_idx_ff >= fill_ff);
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      fill_in      = fill_ff;
      live_in      = live_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = pend_ff;
      res_found_in = res_found_ff;
      res_entry_in = res_entry_ff;
      res_full_in  = res_full_ff;
      if (cmd.start) begin
         rd_idx_in    = '0;
         pend_in      = 1'b0;
         res_found_in = 1'b0;
         res_entry_in = '0;
         res_full_in  = 1'b0;
      end
      if (cmd.add) begin
         if (has_room) begin
            fill_in = fill_ff + 1'b1;
            live_in = live_ff + 1'b1;
         end else begin
            res_full_in = 1'b1;
         end
      end
      if (cmd.step) begin
         pend_in = rd_en;
         if (rd_en) begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
         if (hit) begin
            res_found_in = 1'b1;
            res_entry_in = rd_entry_ff;
         end
      end
      if (rem_wr && (live_ff != '0)) begin
         live_in = live_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign live_sat = (32'(live_ff) > 32'(captbl_pkg::LIVE_MAX)) ?
                     captbl_pkg::LIVE_MAX : captbl_pkg::LIVE_W'(live_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         live_ff      <= '0;
         rd_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         live_ff      <= live_in;
         rd_idx_ff    <= rd_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_found_ff <= res_found_in;
      res_entry_ff <= res_entry_in;
      res_full_ff  <= res_full_in;
      if (cmd.start) begin
         op_ff        <= req_operation;
         key_ff.badge <= req_badge;
         key_ff.kcap  <= req_kcap;
         key_ff.stage <= req_stage_tag;
      end
      if (rd_en) begin
         pend_idx_ff <= rd_idx_ff[IDX_W-1:0];
      end
      if (cmd.load_out) begin
         rsp_found      <= res_found_ff;
         rsp_badge_out  <= res_entry_ff.badge;
         rsp_kcap_out   <= res_entry_ff.kcap;
         rsp_stage_out  <= res_entry_ff.stage;
         rsp_table_full <= res_full_ff;
         rsp_live_count <= live_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (add_wr) begin
         entry_mem[fill_ff[IDX_W-1:0]] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (add_wr) begin
         removed_mem[fill_ff[IDX_W-1:0]] <= 1'b0;
      end else if (rem_wr) begin
         removed_mem[pend_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff   <= entry_mem[rd_idx_ff[IDX_W-1:0]];
         rd_removed_ff <= removed_mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: sv/capability_table_checker.sv
// Port-level assertion checker of the capability table and its bind.
`default_nettype none
`include "capability_table_macros.svh"

module capability_table_checker #(
   parameter int TABLE_DEPTH = 64
) (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_valid,
   input wire logic                                  req_stall,
   input wire logic        [captbl_pkg::OP_W-1:0]    req_operation,
   input wire logic signed [captbl_pkg::BADGE_W-1:0] req_badge,
   input wire logic        [captbl_pkg::KCAP_W-1:0]  req_kcap,
   input wire logic        [captbl_pkg::STAGE_W-1:0] req_stage_tag,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_stall,
   input wire logic                                  rsp_found,
   input wire logic signed [captbl_pkg::BADGE_W-1:0] rsp_badge_out,
   input wire logic        [captbl_pkg::KCAP_W-1:0]  rsp_kcap_out,
   input wire logic        [captbl_pkg::STAGE_W-1:0] rsp_stage_out,
   input wire logic                                  rsp_table_full,
   input wire logic        [captbl_pkg::LIVE_W-1:0]  rsp_live_count
);

   localparam int LIVE_LIM = (TABLE_DEPTH > 127) ? 127 : TABLE_DEPTH;

   logic add_taken;
   logic miss_zero;

   assign add_taken = req_valid && !req_stall && (req_operation == captbl_pkg::OP_ADD) &&
                      (req_badge == req_badge) && (req_kcap == req_kcap) &&
                      (req_stage_tag == req_stage_tag);
   assign miss_zero = (rsp_badge_out == '0) && (rsp_kcap_out == '0) && (rsp_stage_out == '0);

   `CT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_live_count) && $stable(rsp_found), "stalled item changed")
   `CT_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp_found, miss_zero, "miss carries nonzero entry fields")
   `CT_ASSERT_NOW(a_full_miss, rsp_valid && rsp_table_full, !rsp_found, "dropped add reports a match")
   `CT_ASSERT_NOW(a_live_lim, rsp_valid, 32'(rsp_live_count) <= 32'(LIVE_LIM), "live count above table depth")
   `CT_ASSERT_NEXT(a_add_busy, add_taken, req_stall, "request taken during add")

endmodule

bind capability_table capability_table_checker #(
   .TABLE_DEPTH (TABLE_DEPTH)
) u_checker (.*);

`default_nettype wire
